>>> design/ewlr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewlr_pkg: shared types and codes for the wear-leveling ring
// item layouts, opcodes, register indexes, register reset values, fsm states
// ----------------------------------------------------------------------------
package ewlr_pkg;

  localparam int OP_W        = 2;
  localparam int DATA_W      = 64;
  localparam int HEAD_OUT_W  = 6;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_CNT_W   = 7;
  localparam int CFG_BYTES_W = 4;
  localparam int STATUS_W    = 8;

  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ENTRY_BYTES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_FRESH = 2'd2;

  localparam logic [CFG_CNT_W-1:0]   CNT_RST   = 7'd64;
  localparam logic [CFG_BYTES_W-1:0] BYTES_RST = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] write_data;
  } ewlr_in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]     read_data;
    logic [HEAD_OUT_W-1:0] head;
  } ewlr_out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_SCAN
  } ewlr_state_t;

endpackage

>>> design/eeprom_wear_level_ring_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeprom_wear_level_ring_top: wear-leveling ring over internal stores
// ring of entries with a parallel status byte store, init, read and write
// ----------------------------------------------------------------------------
// The block keeps a ring of up to MAX_ENTRIES 64-bit entries and one status
// byte per slot. Both stores are synchronous memories with one read port and
// one write port each, and a registered read. Every item gives exactly one
// result. Init when already initialized, fresh init and unknown opcodes
// finish in the cycle they are taken, with the result registered into the
// output register or the holding slot. Read and write first do the memory
// read of the entry or of the old status byte, then give the result (and for
// write the write-back of entry and status at the new head). A recovering
// init walks the status store one byte per cycle through its read port. The
// stores reset to zero through per-slot valid bits, so there is no clearing
// pass after reset; a fresh init clears the first entry_count status valid
// bits at once. The result sits in an output register with one holding slot
// behind it, so a new item can be taken while a finished result still waits.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module eeprom_wear_level_ring_top
  import ewlr_pkg::*;
#(
  parameter int MAX_ENTRIES     = 64,
  parameter int MAX_ENTRY_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ewlr_in_item_t         in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ewlr_out_item_t        out_item,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int HEAD_W = $clog2(MAX_ENTRIES);
  // count width holds MAX_ENTRIES itself
  localparam int CNT_W  = HEAD_W + 1;
  localparam int BYTES  = DATA_W / 8;

  // configuration registers
  logic [CFG_CNT_W-1:0]   cfg_cnt_r;
  logic [CFG_BYTES_W-1:0] cfg_bytes_r;
  logic                   cfg_fresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cnt_r   <= CNT_RST;
      cfg_bytes_r <= BYTES_RST;
      cfg_fresh_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENTRY_COUNT: cfg_cnt_r   <= cfg_wdata[CFG_CNT_W-1:0];
        CFG_ENTRY_BYTES: cfg_bytes_r <= cfg_wdata[CFG_BYTES_W-1:0];
        CFG_START_FRESH: cfg_fresh_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective entry count, clamped to 1..MAX_ENTRIES
  logic [7:0]       cnt_ext;
  logic [CNT_W-1:0] cnt_eff;

  always_comb begin
    cnt_ext = 8'(cfg_cnt_r);
    if (cnt_ext == 8'd0) begin
      cnt_eff = CNT_W'(1);
    end else if (cnt_ext > 8'(MAX_ENTRIES)) begin
      cnt_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cnt_eff = CNT_W'(cnt_ext);
    end
  end

  // byte mask from the effective byte count
  logic [CFG_BYTES_W-1:0] bytes_eff;
  logic [DATA_W-1:0]      byte_mask;

  always_comb begin
    if (cfg_bytes_r == '0) begin
      bytes_eff = CFG_BYTES_W'(1);
    end else if (cfg_bytes_r > CFG_BYTES_W'(MAX_ENTRY_BYTES)) begin
      bytes_eff = CFG_BYTES_W'(MAX_ENTRY_BYTES);
    end else begin
      bytes_eff = cfg_bytes_r;
    end
    for (int k = 0; k < BYTES; k++) begin
      byte_mask[k*8 +: 8] = (CFG_BYTES_W'(k) < bytes_eff) ? 8'hff : 8'h00;
    end
  end

  // control state
  ewlr_state_t         state_r, state_nxt;
  logic [HEAD_W-1:0]   head_r, head_nxt;
  logic                init_done_r, init_done_nxt;
  logic [HEAD_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [STATUS_W-1:0] scan_prev_r, scan_prev_nxt;
  logic [DATA_W-1:0]   wdata_r;

  // output register and holding slot
  logic           out_vld_r, pend_vld_r;
  ewlr_out_item_t out_item_r, pend_item_r;

  logic accept;
  assign in_ready = (state_r == ST_IDLE) && !pend_vld_r;
  assign accept   = in_valid && in_ready;

  // memories: status bytes and entries, each with per-slot valid bits
  logic [STATUS_W-1:0]    status_mem [MAX_ENTRIES];
  logic [DATA_W-1:0]      entry_mem  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] status_vld_r;
  logic [MAX_ENTRIES-1:0] entry_vld_r;

  logic [HEAD_W-1:0]   st_raddr, en_raddr, st_waddr, en_waddr;
  logic                st_we, en_we, fresh_clr;
  logic [STATUS_W-1:0] st_wdata;
  logic [DATA_W-1:0]   en_wdata;
  logic [STATUS_W-1:0] st_q;
  logic                st_vq;
  logic [DATA_W-1:0]   en_q;
  logic                en_vq;

  always_ff @(posedge clk) begin
    if (st_we) begin
      status_mem[st_waddr] <= st_wdata;
    end
    st_q  <= status_mem[st_raddr];
    st_vq <= status_vld_r[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (en_we) begin
      entry_mem[en_waddr] <= en_wdata;
    end
    en_q  <= entry_mem[en_raddr];
    en_vq <= entry_vld_r[en_raddr];
  end

  // valid bits: reset clears all, fresh init clears the status bits of the slots in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_vld_r <= '0;
      entry_vld_r  <= '0;
    end else begin
      if (fresh_clr) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (CNT_W'(i) < cnt_eff) begin
            status_vld_r[i] <= 1'b0;
          end
        end
      end
      if (st_we) begin
        status_vld_r[st_waddr] <= 1'b1;
      end
      if (en_we) begin
        entry_vld_r[en_waddr] <= 1'b1;
      end
    end
  end

  // a slot never written reads as zero
  logic [STATUS_W-1:0] st_data;
  logic [DATA_W-1:0]   en_data;
  assign st_data = st_vq ? st_q : '0;
  assign en_data = en_vq ? en_q : '0;

  // next head for a write, wrapping at the entry count
  logic [CNT_W-1:0]  nh_w;
  logic [HEAD_W-1:0] new_head;
  assign nh_w     = CNT_W'(head_r) + CNT_W'(1);
  assign new_head = (nh_w >= cnt_eff) ? '0 : nh_w[HEAD_W-1:0];

  // recovery scan: data for slot scan_idx_r arrives this cycle
  logic [CNT_W-1:0] scan_next_w;
  logic             scan_ok, scan_last, scan_end;
  assign scan_next_w = CNT_W'(scan_idx_r) + CNT_W'(1);
  assign scan_ok     = (scan_idx_r == '0) || (st_data == 8'(scan_prev_r + 8'd1));
  assign scan_last   = scan_next_w >= cnt_eff;
  assign scan_end    = !scan_ok || scan_last;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.opcode)
            OP_INIT: begin
              if (!init_done_r && !cfg_fresh_r) begin
                state_nxt = ST_SCAN;
              end
            end
            OP_READ:  state_nxt = ST_READ;
            OP_WRITE: state_nxt = ST_WRITE;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_IDLE;
      ST_WRITE: state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  logic           done;
  ewlr_out_item_t res_item;

  always_comb begin
    st_raddr           = head_r;
    en_raddr           = head_r;
    st_we              = 1'b0;
    st_waddr           = new_head;
    st_wdata           = 8'(st_data + 8'd1);
    en_we              = 1'b0;
    en_waddr           = new_head;
    en_wdata           = wdata_r;
    fresh_clr          = 1'b0;
    done               = 1'b0;
    res_item.read_data = '0;
    res_item.head      = HEAD_OUT_W'(head_r);
    head_nxt           = head_r;
    init_done_nxt      = init_done_r;
    scan_idx_nxt       = scan_idx_r;
    scan_prev_nxt      = scan_prev_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.opcode)
            OP_INIT: begin
              if (init_done_r) begin
                done = 1'b1;
              end else if (cfg_fresh_r) begin
                fresh_clr     = 1'b1;
                head_nxt      = '0;
                init_done_nxt = 1'b1;
                done          = 1'b1;
                res_item.head = '0;
              end else begin
                // start the walk at slot 0
                st_raddr     = '0;
                scan_idx_nxt = '0;
              end
            end
            OP_READ:  ;
            OP_WRITE: ;
            default:  done = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        done               = 1'b1;
        res_item.read_data = en_data;
      end
      ST_WRITE: begin
        // old status is on the read port; write back at the new head
        st_we         = 1'b1;
        en_we         = 1'b1;
        head_nxt      = new_head;
        done          = 1'b1;
        res_item.head = HEAD_OUT_W'(new_head);
      end
      ST_SCAN: begin
        st_raddr = scan_next_w[HEAD_W-1:0];
        if (!scan_ok) begin
          head_nxt      = scan_idx_r - HEAD_W'(1);
          init_done_nxt = 1'b1;
          done          = 1'b1;
          res_item.head = HEAD_OUT_W'(scan_idx_r - HEAD_W'(1));
        end else if (scan_last) begin
          head_nxt      = scan_idx_r;
          init_done_nxt = 1'b1;
          done          = 1'b1;
          res_item.head = HEAD_OUT_W'(scan_idx_r);
        end else begin
          scan_prev_nxt = st_data;
          scan_idx_nxt  = scan_next_w[HEAD_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      init_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      init_done_r <= init_done_nxt;
    end
  end

  // scan and write payload registers
  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    scan_prev_r <= scan_prev_nxt;
    if (accept) begin
      wdata_r <= in_item.write_data & byte_mask;
    end
  end

  // output register with one holding slot behind it
  logic out_free;
  assign out_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (done) begin
        if (out_free) begin
          out_vld_r <= 1'b1;
        end else begin
          pend_vld_r <= 1'b1;
        end
      end else if (pend_vld_r && out_free) begin
        out_vld_r  <= 1'b1;
        pend_vld_r <= 1'b0;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (out_free) begin
        out_item_r <= res_item;
      end else begin
        pend_item_r <= res_item;
      end
    end else if (pend_vld_r && out_free) begin
      out_item_r <= pend_item_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

>>> design/ewlr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewlr_checker: port-level checks for the wear-leveling ring
// watches the item channels of the top level over time
// ----------------------------------------------------------------------------
module ewlr_checker
  import ewlr_pkg::*;
(
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input ewlr_in_item_t  in_item,
  input logic           out_valid,
  input logic           out_ready,
  input ewlr_out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // read and write go through the memory read, so input is closed in the cycle after they are taken
  a_mem_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_item.opcode == OP_READ || in_item.opcode == OP_WRITE)
    |=> !in_ready)
    else $error("input open during memory access");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented after reset");

  // a read taken while the output is empty shows its result after the read state, through the output register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid && in_item.opcode == OP_READ |=> ##1 out_valid)
    else $error("read result missing");

endmodule

bind eeprom_wear_level_ring_top ewlr_checker u_ewlr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
